@@ rtl/core/shell_command_lexer_core_macros.svh @@
// Assertion helpers shared by the lexer core modules.
`ifndef SHELL_COMMAND_LEXER_CORE_MACROS_SVH
`define SHELL_COMMAND_LEXER_CORE_MACROS_SVH

// Same-cycle implication.
`define SCLX_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SCLX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sclx_pkg.sv @@
package sclx_pkg;

   localparam int MaxLength  = 4096;
   localparam int PosWidth   = $clog2(MaxLength + 1);
   localparam int CharWidth  = 8;
   localparam int KindWidth  = 4;
   localparam int QueueDepth = 4;
   localparam int QPtrWidth  = $clog2(QueueDepth);
   localparam int QCntWidth  = $clog2(QueueDepth + 1);

   typedef logic [PosWidth-1:0]  pos_type;
   typedef logic [CharWidth-1:0] char_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_SQ,
      MODE_DQ,
      MODE_AMP,
      MODE_PIPE
   } mode_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_WORD    = 4'd0,
      KIND_SQ      = 4'd1,
      KIND_DQ      = 4'd2,
      KIND_AMP     = 4'd3,
      KIND_AND     = 4'd4,
      KIND_PIPE    = 4'd5,
      KIND_OR      = 4'd6,
      KIND_UNKNOWN = 4'd7,
      KIND_END     = 4'd8
   } kind_type;

   localparam char_type CHAR_NUL        = 8'h00;
   localparam char_type CHAR_TAB        = 8'h09;
   localparam char_type CHAR_CR         = 8'h0D;
   localparam char_type CHAR_SPACE      = 8'h20;
   localparam char_type CHAR_DQUOTE     = 8'h22;
   localparam char_type CHAR_DOLLAR     = 8'h24;
   localparam char_type CHAR_AMP        = 8'h26;
   localparam char_type CHAR_SQUOTE     = 8'h27;
   localparam char_type CHAR_DASH       = 8'h2D;
   localparam char_type CHAR_DOT        = 8'h2E;
   localparam char_type CHAR_SLASH      = 8'h2F;
   localparam char_type CHAR_DIGIT_0    = 8'h30;
   localparam char_type CHAR_DIGIT_9    = 8'h39;
   localparam char_type CHAR_UPPER_A    = 8'h41;
   localparam char_type CHAR_UPPER_Z    = 8'h5A;
   localparam char_type CHAR_UNDERSCORE = 8'h5F;
   localparam char_type CHAR_LOWER_A    = 8'h61;
   localparam char_type CHAR_LOWER_Z    = 8'h7A;
   localparam char_type CHAR_PIPE       = 8'h7C;

   typedef struct packed {
      kind_type kind;
      pos_type  first;
      pos_type  stop;
   } tok_type;

   // one queue entry holds every token raised by one input byte
   typedef struct packed {
      logic    two;
      tok_type tok0;
      tok_type tok1;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qport_type;

   function automatic pos_type sat_inc(input pos_type p);
      return (p < PosWidth'(MaxLength)) ? p + 1'b1 : PosWidth'(MaxLength);
   endfunction

   function automatic logic is_space(input char_type c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_word(input char_type c);
      return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) ||
             (c == CHAR_UNDERSCORE) || (c == CHAR_DASH) ||
             (c == CHAR_DOLLAR) || (c == CHAR_DOT) || (c == CHAR_SLASH);
   endfunction

endpackage

@@ rtl/core/sclx_ifs.sv @@
interface sclx_req_if import sclx_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface sclx_rsp_if import sclx_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] token_kind;
   pos_type              token_start;
   pos_type              token_end;
   logic                 last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_end, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start,
                 input token_end, input last_of_run, output ready);
endinterface

@@ rtl/core/sclx_front.sv @@
`include "shell_command_lexer_core_macros.svh"

module sclx_front import sclx_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sclx_req_if.sink  req_if,
   input  logic      q_full,
   output qport_type push
);

   mode_type mode_ff, mode_in;
   pos_type  pos_ff, pos_in;
   pos_type  origin_ff, origin_in;
   logic     accept;
   logic     idle_path;
   char_type c;
   char_type close_quote;
   char_type pair_op;
   pos_type  p;
   pos_type  p_inc;
   logic     a_emit, b_emit;
   tok_type  a_tok, b_tok;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign c            = req_if.char_code;
   assign p            = pos_ff;
   assign p_inc        = sat_inc(pos_ff);
   assign close_quote  = (mode_ff == MODE_SQ) ? CHAR_SQUOTE : CHAR_DQUOTE;
   assign pair_op      = (mode_ff == MODE_AMP) ? CHAR_AMP : CHAR_PIPE;

   // byte gets idle handling in idle mode, or falls through to it after closing a word or lone operator
   always_comb begin
      case (mode_ff)
         MODE_WORD: begin
            idle_path = !is_word(c);
         end
         MODE_SQ, MODE_DQ: begin
            idle_path = 1'b0;
         end
         MODE_AMP, MODE_PIPE: begin
            idle_path = (c != pair_op);
         end
         default: begin
            idle_path = 1'b1;
         end
      endcase
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      origin_in = origin_ff;
      if (accept) begin
         case (mode_ff)
            MODE_WORD: begin
               if (!idle_path) begin
                  pos_in = p_inc;
               end
            end
            MODE_SQ, MODE_DQ: begin
               if (c == close_quote) begin
                  mode_in = MODE_IDLE;
                  pos_in  = p_inc;
               end else if (c == CHAR_NUL) begin
                  mode_in   = MODE_IDLE;
                  pos_in    = '0;
                  origin_in = '0;
               end else begin
                  pos_in = p_inc;
               end
            end
            MODE_AMP, MODE_PIPE: begin
               if (!idle_path) begin
                  mode_in = MODE_IDLE;
                  pos_in  = p_inc;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
         if (idle_path) begin
            mode_in = MODE_IDLE;
            if (c == CHAR_NUL) begin
               pos_in    = '0;
               origin_in = '0;
            end else if (is_space(c)) begin
               pos_in = p_inc;
            end else if ((c == CHAR_SQUOTE) || (c == CHAR_DQUOTE)) begin
               mode_in   = (c == CHAR_SQUOTE) ? MODE_SQ : MODE_DQ;
               origin_in = p_inc;
               pos_in    = p_inc;
            end else if (is_word(c)) begin
               mode_in   = MODE_WORD;
               origin_in = p;
               pos_in    = p_inc;
            end else if ((c == CHAR_AMP) || (c == CHAR_PIPE)) begin
               mode_in   = (c == CHAR_AMP) ? MODE_AMP : MODE_PIPE;
               origin_in = p;
               pos_in    = p_inc;
            end else begin
               pos_in = p_inc;
            end
         end
      end
   end

   // tokens raised by this byte: a closes the open token, b comes from idle handling or a zero byte in quotes
   always_comb begin
      a_emit = 1'b0;
      a_tok  = '{kind: KIND_WORD, first: origin_ff, stop: p};
      b_emit = 1'b0;
      b_tok  = '{kind: KIND_END, first: p, stop: p};
      case (mode_ff)
         MODE_WORD: begin
            a_emit = idle_path;
         end
         MODE_SQ, MODE_DQ: begin
            a_tok.kind = (mode_ff == MODE_SQ) ? KIND_SQ : KIND_DQ;
            a_emit     = (c == close_quote) || (c == CHAR_NUL);
            b_emit     = (c != close_quote) && (c == CHAR_NUL);
         end
         MODE_AMP, MODE_PIPE: begin
            a_emit = 1'b1;
            if (!idle_path) begin
               a_tok.kind = (mode_ff == MODE_AMP) ? KIND_AND : KIND_OR;
               a_tok.stop = p_inc;
            end else begin
               a_tok.kind = (mode_ff == MODE_AMP) ? KIND_AMP : KIND_PIPE;
            end
         end
         default: begin
            a_emit = 1'b0;
         end
      endcase
      if (idle_path) begin
         if (c == CHAR_NUL) begin
            b_emit = 1'b1;
         end else if (!is_space(c) && !is_word(c) && (c != CHAR_SQUOTE) &&
                      (c != CHAR_DQUOTE) && (c != CHAR_AMP) && (c != CHAR_PIPE)) begin
            b_emit = 1'b1;
            b_tok  = '{kind: KIND_UNKNOWN, first: p, stop: p_inc};
         end
      end
      push.valid      = accept && (a_emit || b_emit);
      push.entry.two  = a_emit && b_emit;
      push.entry.tok0 = a_emit ? a_tok : b_tok;
      push.entry.tok1 = b_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         origin_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         origin_ff <= origin_in;
      end
   end

   `SCLX_ASSERT_IMPLY(a_origin_le_pos, mode_ff != MODE_IDLE, pos_ff >= origin_ff, "origin past position")
   `SCLX_ASSERT_NEXT(a_nul_rewinds, accept && (c == CHAR_NUL), pos_ff == '0, "end of line did not rewind")

endmodule

@@ rtl/core/sclx_queue.sv @@
`include "shell_command_lexer_core_macros.svh"

module sclx_queue import sclx_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qport_type push,
   output logic      full,
   output qport_type head,
   input  logic      pop
);

   entry_type               slots_ff [QueueDepth];
   logic [QPtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCntWidth-1:0]    count_ff, count_in;

   assign full       = (count_ff == QCntWidth'(QueueDepth));
   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SCLX_ASSERT_IMPLY(a_no_overflow, push.valid, !full, "push into full queue")
   `SCLX_ASSERT_IMPLY(a_no_underflow, pop, count_ff != '0, "pop from empty queue")

endmodule

@@ rtl/core/sclx_back.sv @@
`include "shell_command_lexer_core_macros.svh"

module sclx_back import sclx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  qport_type  head,
   output logic       pop,
   sclx_rsp_if.source rsp_if
);

   logic    out_valid_ff, out_valid_in;
   tok_type out_tok_ff, out_tok_in;
   logic    out_last_ff, out_last_in;
   logic    pend_valid_ff, pend_valid_in;
   tok_type pend_tok_ff, pend_tok_in;
   logic    advance;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign pop     = advance && !pend_valid_ff && head.valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_tok_in    = out_tok_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_tok_in   = pend_tok_ff;
      if (advance) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_tok_in    = pend_tok_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else if (head.valid) begin
            out_valid_in  = 1'b1;
            out_tok_in    = head.entry.tok0;
            out_last_in   = !head.entry.two;
            pend_valid_in = head.entry.two;
            pend_tok_in   = head.entry.tok1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff  <= out_tok_in;
      out_last_ff <= out_last_in;
      pend_tok_ff <= pend_tok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.token_kind  = out_tok_ff.kind;
   assign rsp_if.token_start = out_tok_ff.first;
   assign rsp_if.token_end   = out_tok_ff.stop;
   assign rsp_if.last_of_run = out_last_ff;

   `SCLX_ASSERT_IMPLY(a_pend_behind_out, pend_valid_ff, out_valid_ff && !out_last_ff, "second token without first")

endmodule

@@ rtl/core/shell_command_lexer_core.sv @@
// Streaming lexer for a shell command line.
// req_if carries one byte per transfer (char_code); a zero byte ends the line,
// emits an end token and rewinds the position to 0.
// rsp_if carries one token per transfer: kind, start, exclusive end and
// last_of_run, which marks the final token raised by one input byte.
// A byte is taken every cycle while the four-entry token queue has room.
// A token closed by a taken byte is stored in the queue and then registered in the
// output stage before it appears on rsp_if; a byte that raises two tokens sends
// them through the output register one after the other, absorbed by the queue.
// Sustained rate: one byte per cycle while the queue has room, set by the mode update.
// When the receiver stalls, the output holds and the queue fills; req_if.ready
// drops only once the queue is full.
// Reset (synchronous) returns the lexer to idle at position 0 and empties the
// queue and output stage.
module shell_command_lexer_core import sclx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sclx_req_if.sink   req_if,
   sclx_rsp_if.source rsp_if
);

   qport_type push;
   qport_type head;
   logic      q_full;
   logic      pop;

   sclx_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .push   (push)
   );

   sclx_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   sclx_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
